@@ rtl/matrix_power_2x2_top_macros.svh @@
// Assertion macros used by the checker file of the matrix power block.
`ifndef MATRIX_POWER_2X2_TOP_MACROS_SVH
`define MATRIX_POWER_2X2_TOP_MACROS_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define MP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Asserts that an antecedent implies a consequent in the next cycle.
`define MP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/mp2_pkg.sv @@
// Package with shared constants and types of the matrix power block.
package mp2_pkg;
  localparam int unsigned DataW   = 64;
  localparam int unsigned ExpBits = 32;
  localparam int unsigned DigitW  = 8;
  localparam int unsigned Digits  = DataW / DigitW;
  localparam int unsigned DigW    = $clog2(Digits);
  localparam int unsigned ExpCntW = $clog2(ExpBits + 1);
  localparam int unsigned AddrW   = 5;

  localparam logic [AddrW-1:0] AddrTopLeft     = 5'h00;
  localparam logic [AddrW-1:0] AddrTopRight    = 5'h08;
  localparam logic [AddrW-1:0] AddrBottomLeft  = 5'h10;
  localparam logic [AddrW-1:0] AddrBottomRight = 5'h18;

  typedef logic [DataW-1:0] word_t;

  // Command from the sequencer to the serial multiply-accumulate unit.
  typedef struct packed {
    logic  start;
    logic  clear;
    word_t a;
    word_t b;
  } mac_cmd_t;

  typedef struct packed {
    logic  done;
    word_t acc;
  } mac_rsp_t;
endpackage

@@ rtl/mp2_mac.sv @@
// Digit-serial 64-bit multiply-accumulate unit, eight bits of one operand a cycle.
module mp2_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mp2_pkg::mac_cmd_t cmd_i,
  output mp2_pkg::mac_rsp_t rsp_o
);
  logic                      busy_q, busy_d;
  logic [mp2_pkg::DigW-1:0]  cnt_q, cnt_d;
  mp2_pkg::word_t            a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic                      done_q, done_d;
  logic [mp2_pkg::DataW+mp2_pkg::DigitW-1:0] part;

  // One 64x8 partial product per cycle, shifted into place by the multiplicand shift.
  assign part = a_q * b_q[mp2_pkg::DigitW-1:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = cmd_i.a;
      b_d    = cmd_i.b;
      if (cmd_i.clear) acc_d = '0;
    end else if (busy_q) begin
      acc_d = acc_q + part[mp2_pkg::DataW-1:0];
      a_d   = a_q << mp2_pkg::DigitW;
      b_d   = b_q >> mp2_pkg::DigitW;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mp2_pkg::DigW'(mp2_pkg::Digits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.acc  = acc_q;
endmodule

@@ rtl/matrix_power_2x2_top.sv @@
// Top level of the matrix power block: register port, sequencer and output register.
//
// This block raises a configured 2x2 base matrix to the power of a 32-bit
// exponent by square-and-multiply, scanning the exponent from its least
// significant bit, with all entries unsigned and wrapping modulo 2^64. The
// base resets to the Fibonacci matrix, so by default the result words are
// F(n+1), F(n), F(n) and F(n-1). All arithmetic runs on one shared
// multiply-accumulate unit that takes one 8-bit digit of the multiplier per
// cycle. One 64-bit product is a start step, eight digit steps and the step in
// which the done flag is seen. One matrix entry is two products, and one 2x2
// product is four entries. For every exponent bit up to the highest set bit
// the block spends one decision step, squares the running matrix and, where
// the bit is set, first multiplies it into the result. A zero exponent goes
// straight from the decision state to the output state. One item is worked
// on at a time; a finished word waits in the output register while the next
// exponent is accepted and worked on, and that next result is only moved
// out once the waiting word has been taken. The base registers sit at byte
// addresses 0, 8, 16 and 24 of the 64-bit register port, and a new base
// takes effect with the next exponent.
module matrix_power_2x2_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mp2_pkg::AddrW-1:0]  paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  input  logic                       exponent_valid_i,
  output logic                       exponent_stall_o,
  input  logic [31:0]                exponent_i,
  output logic                       power_valid_o,
  input  logic                       power_stall_i,
  output logic [63:0]                power_top_left_o,
  output logic [63:0]                power_top_right_o,
  output logic [63:0]                power_bottom_left_o,
  output logic [63:0]                power_bottom_right_o
);
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StBit  = 5'b00010,
    StMac  = 5'b00100,
    StNext = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  mp2_pkg::word_t base_q [4];
  mp2_pkg::word_t acc_q [4], acc_d [4];
  mp2_pkg::word_t sq_q [4], sq_d [4];
  mp2_pkg::word_t tmp_q [4], tmp_d [4];
  logic [mp2_pkg::ExpBits-1:0] exp_q, exp_d;
  logic [mp2_pkg::ExpCntW-1:0] bits_q, bits_d;
  logic mul_q, mul_d;          // 1: multiplying into result, 0: squaring
  logic [1:0] ent_q, ent_d;    // matrix entry being formed
  logic term_q, term_d;        // which of the two products of the entry
  logic out_v_q, out_v_d;
  mp2_pkg::word_t out_q [4], out_d [4];
  mp2_pkg::mac_cmd_t cmd;
  mp2_pkg::mac_rsp_t rsp;
  logic [1:0] ia, ib;
  logic in_acc, wr;

  mp2_mac u_mac (.clk_i, .rst_ni, .cmd_i(cmd), .rsp_o(rsp));

  // Register port.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  always_comb begin
    unique case (paddr)
      mp2_pkg::AddrTopLeft:     prdata = base_q[0];
      mp2_pkg::AddrTopRight:    prdata = base_q[1];
      mp2_pkg::AddrBottomLeft:  prdata = base_q[2];
      mp2_pkg::AddrBottomRight: prdata = base_q[3];
      default:                  prdata = '0;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q[0] <= 64'd1;
      base_q[1] <= 64'd1;
      base_q[2] <= 64'd1;
      base_q[3] <= 64'd0;
    end else if (wr) begin
      unique case (paddr)
        mp2_pkg::AddrTopLeft:     base_q[0] <= pwdata;
        mp2_pkg::AddrTopRight:    base_q[1] <= pwdata;
        mp2_pkg::AddrBottomLeft:  base_q[2] <= pwdata;
        mp2_pkg::AddrBottomRight: base_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // Entry r*2+c = sum over k of L[r][k] * S[k][c]; L is the result or the square.
  assign ia  = {ent_q[1], term_q};
  assign ib  = {term_q, ent_q[0]};
  assign in_acc = (state_q == StIdle) && exponent_valid_i && !exponent_stall_o;
  assign exponent_stall_o = (state_q != StIdle);

  always_comb begin
    state_d   = state_q;
    exp_d     = exp_q;
    bits_d    = bits_q;
    mul_d     = mul_q;
    ent_d     = ent_q;
    term_d    = term_q;
    acc_d     = acc_q;
    sq_d      = sq_q;
    tmp_d     = tmp_q;
    out_v_d   = out_v_q;
    out_d     = out_q;
    cmd.start = 1'b0;
    cmd.clear = !term_q;
    cmd.a     = mul_q ? acc_q[ia] : sq_q[ia];
    cmd.b     = sq_q[ib];
    if (out_v_q && !power_stall_i) out_v_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          exp_d    = exponent_i;
          bits_d   = '0;
          acc_d[0] = 64'd1;
          acc_d[1] = 64'd0;
          acc_d[2] = 64'd0;
          acc_d[3] = 64'd1;
          sq_d     = base_q;
          state_d  = StBit;
        end
      end
      StBit: begin
        if (exp_q == '0 || bits_q == mp2_pkg::ExpCntW'(mp2_pkg::ExpBits)) begin
          state_d = StOut;
        end else begin
          mul_d     = exp_q[0];
          ent_d     = '0;
          term_d    = 1'b0;
          state_d   = StMac;
        end
      end
      StMac: begin
        cmd.start = 1'b1;
        state_d   = StNext;
      end
      StNext: begin
        if (rsp.done) begin
          if (!term_q) begin
            term_d  = 1'b1;
            state_d = StMac;
          end else begin
            tmp_d[ent_q] = rsp.acc;
            term_d = 1'b0;
            if (ent_q != 2'd3) begin
              ent_d   = ent_q + 1'b1;
              state_d = StMac;
            end else if (mul_q) begin
              acc_d   = tmp_d;
              mul_d   = 1'b0;
              ent_d   = '0;
              state_d = StMac;
            end else begin
              sq_d    = tmp_d;
              exp_d   = exp_q >> 1;
              bits_d  = bits_q + 1'b1;
              state_d = StBit;
            end
          end
        end
      end
      StOut: begin
        if (!out_v_q) begin
          out_d   = acc_q;
          out_v_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
      exp_q   <= '0;
      bits_q  <= '0;
      mul_q   <= 1'b0;
      ent_q   <= '0;
      term_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      exp_q   <= exp_d;
      bits_q  <= bits_d;
      mul_q   <= mul_d;
      ent_q   <= ent_d;
      term_q  <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sq_q  <= sq_d;
    tmp_q <= tmp_d;
    out_q <= out_d;
  end

  assign power_valid_o        = out_v_q;
  assign power_top_left_o     = out_q[0];
  assign power_top_right_o    = out_q[1];
  assign power_bottom_left_o  = out_q[2];
  assign power_bottom_right_o = out_q[3];
endmodule

@@ rtl/mp2_checker.sv @@
// Port-level checker of the matrix power block and its bind statement.
`include "matrix_power_2x2_top_macros.svh"
module mp2_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        exponent_valid_i,
  input logic        exponent_stall_o,
  input logic        power_valid_o,
  input logic        power_stall_i,
  input logic [63:0] power_top_left_o,
  input logic [63:0] power_bottom_right_o,
  input logic        pready
);
  logic held;

  assign held = power_valid_o && power_stall_i;

  `MP_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)
  `MP_ASSERT_NEXT(a_hold, clk_i, rst_ni, held, power_valid_o)
  `MP_ASSERT_NEXT(a_hold_tl, clk_i, rst_ni, held, $stable(power_top_left_o))
  `MP_ASSERT_NEXT(a_hold_br, clk_i, rst_ni, held, $stable(power_bottom_right_o))
  `MP_ASSERT_NEXT(a_busy, clk_i, rst_ni, exponent_valid_i && !exponent_stall_o, exponent_stall_o)
endmodule

bind matrix_power_2x2_top mp2_checker u_mp2_checker (.*);
